// ===== design/qbps_pkg.sv =====
// Package for the quadratic Bezier path stepper.
// Shared widths, register indexes, sequencer states and the control word.
// No dependencies.
`default_nettype none

package qbps_pkg;

    // default field widths and fixed formats
    localparam int CoordWidthDef = 20;   // signed Q11.8 coordinates
    localparam int TFracDef      = 16;   // fraction bits of t
    localparam int StepW         = 16;   // time_step, unsigned Q0.16
    localparam int RateW         = 16;   // flight_rate, unsigned Q8.8
    localparam int RateProdFrac  = 24;   // fraction bits of step * rate
    localparam int RegIdxW       = 2;    // config register index width
    localparam int Axes          = 3;

    localparam logic [RateW-1:0] RateReset = 16'd256;  // 1.0 in Q8.8

    // configuration register indexes
    typedef enum logic [RegIdxW-1:0] {
        REG_START   = 2'd0,
        REG_CONTROL = 2'd1,
        REG_END     = 2'd2,
        REG_RATE    = 2'd3
    } t_reg_idx;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INC,     // step * rate
        ST_TUP,     // advance t, saturate
        ST_USQ,     // u * u
        ST_TSQ,     // t * t, round w0
        ST_W1,      // round w2, form w1
        ST_MAC,     // nine weight * coordinate products
        ST_DRAIN,   // last product lands in the z point register
        ST_OUT      // hand the point to the output register
    } t_state;

    // which control point a blend term uses
    typedef enum logic [1:0] {
        TERM_P0,
        TERM_P1,
        TERM_P2
    } t_term;

    // control word from sequencer to datapath
    typedef struct packed {
        logic       clr_t;     // restart request: t back to zero
        logic       take;      // tick request taken: latch time_step
        logic       inc;
        logic       tup;
        logic       sq_u;
        logic       sq_t;
        logic       w1;
        logic       mac;
        t_term      term;
        logic [1:0] axis;
    } t_ctrl;

endpackage

`default_nettype wire

// ===== design/qbps_dpath.sv =====
// Datapath of the path stepper: one shared signed multiplier, t and weight
// registers, the blend accumulator and the per-axis point registers.
// Depends on qbps_pkg.
`default_nettype none

module qbps_dpath
    import qbps_pkg::*;
#(
    parameter int COORD_WIDTH = CoordWidthDef,
    parameter int T_FRAC_BITS = TFracDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_ctrl                         i_ctrl,
    input  logic [StepW-1:0]              i_step,
    input  logic [RateW-1:0]              i_rate,
    input  logic [3*COORD_WIDTH-1:0]      i_p0,
    input  logic [3*COORD_WIDTH-1:0]      i_p1,
    input  logic [3*COORD_WIDTH-1:0]      i_p2,
    output logic                          o_sat,
    output logic signed [COORD_WIDTH-1:0] o_pos_x,
    output logic signed [COORD_WIDTH-1:0] o_pos_y,
    output logic signed [COORD_WIDTH-1:0] o_pos_z,
    output logic                          o_arrived
);

    localparam int CW  = COORD_WIDTH;
    localparam int TF  = T_FRAC_BITS;
    localparam int WW  = TF + 1;                         // t, u and weights
    localparam int IW  = TF + 8;                         // increment of t
    localparam int SW  = TF + 9;                         // t + increment
    localparam int SH  = RateProdFrac - TF;
    localparam int MA  = (WW > StepW) ? WW : StepW;      // unsigned operand
    localparam int MB0 = (CW > TF + 2) ? CW : TF + 2;
    localparam int MB  = (MB0 > RateW + 1) ? MB0 : RateW + 1;  // signed operand
    localparam int PW  = MA + MB + 1;
    localparam int QW  = 2 * TF + 2;                     // square plus half
    localparam int AW  = TF + CW + 2;                    // blend accumulator

    localparam logic [WW-1:0] TOne    = {1'b1, {TF{1'b0}}};
    localparam logic [QW-1:0] SqHalf  = QW'(1) << (TF - 1);
    localparam logic [AW-1:0] AccHalf = AW'(1) << (TF - 1);

    logic [StepW-1:0]         r_step;
    logic [WW-1:0]            r_t;
    logic                     r_arrived;
    logic [WW-1:0]            r_w0, r_w1, r_w2;
    logic signed [PW-1:0]     r_prod;
    logic                     r_mac_v;
    t_term                    r_mac_term;
    logic [1:0]               r_mac_axis;
    logic signed [AW-1:0]     r_acc;
    logic signed [CW-1:0]     r_pos_x, r_pos_y, r_pos_z;

    logic [MA-1:0]            op_a;
    logic signed [MB-1:0]     op_b;
    logic signed [PW-1:0]     prod;
    logic [WW-1:0]            u_val;
    logic [WW-1:0]            sel_w;
    logic [3*CW-1:0]          sel_pt;
    logic signed [CW-1:0]     sel_c;
    logic [IW-1:0]            inc;
    logic [SW-1:0]            t_sum;
    logic                     sat;
    logic [QW-1:0]            sq_rnd;
    logic [WW-1:0]            w_rnd;
    logic signed [AW-1:0]     term_prod;
    logic signed [AW-1:0]     acc_fin;

    assign u_val = TOne - r_t;

    // operand selection for the shared multiplier
    always_comb begin
        op_a   = '0;
        op_b   = '0;
        sel_w  = r_w0;
        sel_pt = i_p0;
        case (i_ctrl.term)
            TERM_P0: begin
                sel_w  = r_w0;
                sel_pt = i_p0;
            end
            TERM_P1: begin
                sel_w  = r_w1;
                sel_pt = i_p1;
            end
            TERM_P2: begin
                sel_w  = r_w2;
                sel_pt = i_p2;
            end
            default: begin
                sel_w  = r_w0;
                sel_pt = i_p0;
            end
        endcase
        case (i_ctrl.axis)
            2'd0:    sel_c = sel_pt[0 +: CW];
            2'd1:    sel_c = sel_pt[CW +: CW];
            2'd2:    sel_c = sel_pt[2*CW +: CW];
            default: sel_c = sel_pt[0 +: CW];
        endcase
        if (i_ctrl.inc) begin
            op_a = MA'(r_step);
            op_b = MB'(i_rate);
        end else if (i_ctrl.sq_u) begin
            op_a = MA'(u_val);
            op_b = MB'(u_val);
        end else if (i_ctrl.sq_t) begin
            op_a = MA'(r_t);
            op_b = MB'(r_t);
        end else if (i_ctrl.mac) begin
            op_a = MA'(sel_w);
            op_b = MB'(sel_c);
        end
    end

    assign prod = $signed({1'b0, op_a}) * op_b;

    // t advance from the registered step * rate
    assign inc   = r_prod[SH +: IW];
    assign t_sum = SW'(r_t) + SW'(inc);
    assign sat   = (t_sum >= SW'(TOne));
    assign o_sat = i_ctrl.tup & sat;

    // rounded square, half up
    assign sq_rnd = r_prod[QW-1:0] + SqHalf;
    assign w_rnd  = sq_rnd[TF +: WW];

    // blend accumulation; the rounding half rides in with the first term
    assign term_prod = r_prod[AW-1:0];
    assign acc_fin   = r_acc + term_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t       <= '0;
            r_arrived <= 1'b0;
            r_mac_v   <= 1'b0;
        end else begin
            r_mac_v <= i_ctrl.mac;
            if (i_ctrl.clr_t) begin
                r_t <= '0;
            end else if (i_ctrl.tup) begin
                r_t       <= sat ? TOne : t_sum[WW-1:0];
                r_arrived <= sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= prod;
        r_mac_term <= i_ctrl.term;
        r_mac_axis <= i_ctrl.axis;
        if (i_ctrl.take) begin
            r_step <= i_step;
        end
        if (i_ctrl.sq_t) begin
            r_w0 <= w_rnd;
        end
        if (i_ctrl.w1) begin
            r_w2 <= w_rnd;
            r_w1 <= TOne - r_w0 - w_rnd;
        end
        if (r_mac_v) begin
            case (r_mac_term)
                TERM_P0: r_acc <= term_prod + $signed(AccHalf);
                TERM_P1: r_acc <= acc_fin;
                TERM_P2: begin
                    case (r_mac_axis)
                        2'd0:    r_pos_x <= acc_fin[TF +: CW];
                        2'd1:    r_pos_y <= acc_fin[TF +: CW];
                        2'd2:    r_pos_z <= acc_fin[TF +: CW];
                        default: r_pos_x <= acc_fin[TF +: CW];
                    endcase
                end
                default: r_acc <= acc_fin;
            endcase
        end
    end

    assign o_pos_x   = r_pos_x;
    assign o_pos_y   = r_pos_y;
    assign o_pos_z   = r_pos_z;
    assign o_arrived = r_arrived;

endmodule

`default_nettype wire

// ===== design/qbps_ctrl.sv =====
// Sequencer of the path stepper: flight flag, request handshake and the
// per-cycle schedule of the shared multiplier.
// Depends on qbps_pkg.
`default_nettype none

module qbps_ctrl
    import qbps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_restart,
    input  logic  i_sat,
    input  logic  i_out_free,
    output logic  o_in_ready,
    output logic  o_load_out,
    output t_ctrl o_ctrl
);

    t_state     r_state, n_state;
    logic       r_flying, n_flying;
    t_term      r_term, n_term;
    logic [1:0] r_axis, n_axis;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_flying <= 1'b0;
            r_term   <= TERM_P0;
            r_axis   <= '0;
        end else begin
            r_state  <= n_state;
            r_flying <= n_flying;
            r_term   <= n_term;
            r_axis   <= n_axis;
        end
    end

    // next state and schedule
    always_comb begin
        n_state    = r_state;
        n_flying   = r_flying;
        n_term     = r_term;
        n_axis     = r_axis;
        o_ctrl     = '0;
        o_in_ready = 1'b0;
        o_load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_restart) begin
                        o_ctrl.clr_t = 1'b1;
                        n_flying     = 1'b1;
                    end else if (r_flying) begin
                        o_ctrl.take = 1'b1;
                        n_state     = ST_INC;
                    end
                end
            end
            ST_INC: begin
                o_ctrl.inc = 1'b1;
                n_state    = ST_TUP;
            end
            ST_TUP: begin
                o_ctrl.tup = 1'b1;
                if (i_sat) begin
                    n_flying = 1'b0;
                end
                n_state = ST_USQ;
            end
            ST_USQ: begin
                o_ctrl.sq_u = 1'b1;
                n_state     = ST_TSQ;
            end
            ST_TSQ: begin
                o_ctrl.sq_t = 1'b1;
                n_state     = ST_W1;
            end
            ST_W1: begin
                o_ctrl.w1 = 1'b1;
                n_term    = TERM_P0;
                n_axis    = '0;
                n_state   = ST_MAC;
            end
            ST_MAC: begin
                o_ctrl.mac  = 1'b1;
                o_ctrl.term = r_term;
                o_ctrl.axis = r_axis;
                case (r_term)
                    TERM_P0: n_term = TERM_P1;
                    TERM_P1: n_term = TERM_P2;
                    default: begin
                        n_term = TERM_P0;
                        if (r_axis == 2'(Axes - 1)) begin
                            n_state = ST_DRAIN;
                        end else begin
                            n_axis = r_axis + 2'd1;
                        end
                    end
                endcase
            end
            ST_DRAIN: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (i_out_free) begin
                    o_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== design/quadratic_bezier_path_stepper.sv =====
// Top level of the quadratic Bezier path stepper: configuration registers,
// output register, sequencer and shared-multiplier datapath.
// Depends on qbps_pkg, qbps_ctrl and qbps_dpath.
//
//  channel   | direction | tdata                       | tuser
//  ----------+-----------+-----------------------------+---------
//  s_axis    | in        | time_step                   | restart
//  m_axis    | out       | pos_x, pos_y, pos_z, pad 0  | arrived
//  cfg       | in        | we / addr / data, no read   | -
//
// A tick request that produces a point passes from acceptance to the output
// register through twelve passes of the one multiplier (step * rate,
// u squared, t squared, nine weight * coordinate products) and a drain state;
// the next request can be taken in the cycle after the point is loaded.
// Restart requests and ticks while not in flight give no point.
// Reset is synchronous, active low: flight disarmed, t zero, points zero,
// rate 1.0. The next request is taken while a point waits on a stalled
// output; a new point waits in the sequencer until the output register frees.
`default_nettype none

module quadratic_bezier_path_stepper
    import qbps_pkg::*;
#(
    parameter int COORD_WIDTH = CoordWidthDef,
    parameter int T_FRAC_BITS = TFracDef
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request side
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [StepW-1:0]                    i_s_axis_tdata,  // time_step
    input  logic                                i_s_axis_tuser,  // restart
    // result side
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // pos_x, pos_y, pos_z, zero pad
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]  o_m_axis_tdata,
    output logic                                o_m_axis_tuser,  // arrived
    // configuration
    input  logic                                i_cfg_we,
    input  logic [RegIdxW-1:0]                  i_cfg_addr,
    input  logic [3*COORD_WIDTH-1:0]            i_cfg_data
);

    localparam int PtW      = 3 * COORD_WIDTH;
    localparam int OutDataW = ((PtW + 7) / 8) * 8;

    logic [PtW-1:0]   r_p0, r_p1, r_p2;
    logic [RateW-1:0] r_rate;
    logic             r_out_valid;
    logic [PtW-1:0]   r_out_pos;
    logic             r_out_arrived;

    t_ctrl                         ctrl;
    logic                          sat;
    logic                          load_out;
    logic                          out_free;
    logic signed [COORD_WIDTH-1:0] pos_x, pos_y, pos_z;
    logic                          arrived;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0   <= '0;
            r_p1   <= '0;
            r_p2   <= '0;
            r_rate <= RateReset;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_addr))
                REG_START:   r_p0   <= i_cfg_data;
                REG_CONTROL: r_p1   <= i_cfg_data;
                REG_END:     r_p2   <= i_cfg_data;
                REG_RATE:    r_rate <= i_cfg_data[RateW-1:0];
                default:     r_rate <= r_rate;
            endcase
        end
    end

    assign out_free = !r_out_valid || i_m_axis_tready;

    qbps_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_axis_tvalid),
        .i_in_restart (i_s_axis_tuser),
        .i_sat        (sat),
        .i_out_free   (out_free),
        .o_in_ready   (o_s_axis_tready),
        .o_load_out   (load_out),
        .o_ctrl       (ctrl)
    );

    qbps_dpath #(
        .COORD_WIDTH (COORD_WIDTH),
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (ctrl),
        .i_step    (i_s_axis_tdata),
        .i_rate    (r_rate),
        .i_p0      (r_p0),
        .i_p1      (r_p1),
        .i_p2      (r_p2),
        .o_sat     (sat),
        .o_pos_x   (pos_x),
        .o_pos_y   (pos_y),
        .o_pos_z   (pos_z),
        .o_arrived (arrived)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_pos     <= {pos_z, pos_y, pos_x};
            r_out_arrived <= arrived;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OutDataW'(r_out_pos);
    assign o_m_axis_tuser  = r_out_arrived;

endmodule

`default_nettype wire

// ===== design/qbps_chk.sv =====
// Port-level checker for the path stepper, bound to the top level.
// Depends on qbps_pkg and quadratic_bezier_path_stepper.
`default_nettype none

module qbps_chk
    import qbps_pkg::*;
#(
    parameter int COORD_WIDTH = CoordWidthDef
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_s_axis_tvalid,
    input logic                               o_s_axis_tready,
    input logic                               i_s_axis_tuser,
    input logic                               o_m_axis_tvalid,
    input logic                               i_m_axis_tready,
    input logic [((3*COORD_WIDTH+7)/8)*8-1:0] o_m_axis_tdata,
    input logic                               o_m_axis_tuser
);

    // reset empties the output and leaves the block ready
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_rst_rdy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("not ready after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // a restart request never starts a computation
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser |=> o_s_axis_tready)
        else $error("busy after restart request");

    // a new result only comes out of a busy sequencer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(!o_s_axis_tready))
        else $error("result without computation");

endmodule

bind quadratic_bezier_path_stepper qbps_chk #(
    .COORD_WIDTH (COORD_WIDTH)
) u_qbps_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tuser  (i_s_axis_tuser),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

`default_nettype wire

// ===== test/qbps_point_checker.sv =====
`timescale 1ns / 100ps
// Point checker for the quadratic Bezier path stepper: follows the register
// writes and the accepted requests, predicts each curve point, and compares
// the points leaving the block in order. Depends on qbps_pkg.

module qbps_point_checker
    import qbps_pkg::*;
(
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel, watched only
    input  logic                         i_req_valid,
    input  logic                         i_req_ready,
    input  logic [StepW-1:0]             i_req_step,
    input  logic                         i_req_restart,
    // point channel, watched only
    input  logic                         i_pt_valid,
    input  logic                         i_pt_ready,
    input  logic [((3*CoordWidthDef+7)/8)*8-1:0] i_pt_data,
    input  logic                         i_pt_arrived,
    // register writes
    input  logic                         i_cfg_we,
    input  logic [RegIdxW-1:0]           i_cfg_addr,
    input  logic [3*CoordWidthDef-1:0]   i_cfg_data,
    // status for the stimulus side
    output int                           o_fail_count,
    output int                           o_pending
);

    localparam int     CW    = CoordWidthDef;
    localparam int     PtW   = ((3*CW+7)/8)*8;
    localparam longint TOne  = longint'(1) << TFracDef;
    localparam longint THalf = TOne >> 1;

    typedef struct packed {
        logic [CW-1:0] x;
        logic [CW-1:0] y;
        logic [CW-1:0] z;
        logic          arrived;
    } t_point;

    // shadow of the registers and of the flight state
    logic [3*CW-1:0] path_pt [3];
    logic [RateW-1:0] rate_q;
    longint          t_param;
    bit              armed;

    t_point point_q [$];
    t_point want;
    int     fails;
    int     seen;

    function automatic longint coord(t_term term, int axis);
        logic signed [CW-1:0] c;
        c = path_pt[term][axis*CW +: CW];
        return longint'(c);
    endfunction

    // weighted sum of one axis, rounded half up
    function automatic logic [CW-1:0] blend(int axis, longint w0, longint w1, longint w2);
        longint acc;
        acc = w0 * coord(TERM_P0, axis) + w1 * coord(TERM_P1, axis)
            + w2 * coord(TERM_P2, axis);
        acc = (acc + THalf) >>> TFracDef;
        return acc[CW-1:0];
    endfunction

    // advance the flight by one request, queue the point it gives
    task automatic take_request(input bit restart, input logic [StepW-1:0] step);
        longint inc;
        longint t;
        longint u;
        longint w0;
        longint w1;
        longint w2;
        t_point pt;
        if (restart) begin
            t_param = 0;
            armed   = 1'b1;
        end else if (armed) begin
            inc = (longint'(step) * longint'(rate_q)) >> (RateProdFrac - TFracDef);
            t = t_param + inc;
            pt.arrived = (t >= TOne);
            if (pt.arrived) begin
                t     = TOne;
                armed = 1'b0;
            end
            t_param = t;
            u  = TOne - t;
            w0 = (u * u + THalf) >> TFracDef;
            w2 = (t * t + THalf) >> TFracDef;
            w1 = TOne - w0 - w2;
            pt.x = blend(0, w0, w1, w2);
            pt.y = blend(1, w0, w1, w2);
            pt.z = blend(2, w0, w1, w2);
            point_q.push_back(pt);
        end
    endtask

    task automatic check_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v) begin
            fails++;
            $display("%0t: point %0d %s mismatch, expected %h actual %h",
                     $time, seen, name, exp_v, act_v);
        end
    endtask

    initial begin
        fails     = 0;
        seen      = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            path_pt[TERM_P0] = '0;
            path_pt[TERM_P1] = '0;
            path_pt[TERM_P2] = '0;
            rate_q  = RateReset;
            t_param = 0;
            armed   = 1'b0;
            point_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_START:   path_pt[TERM_P0] = i_cfg_data;
                    REG_CONTROL: path_pt[TERM_P1] = i_cfg_data;
                    REG_END:     path_pt[TERM_P2] = i_cfg_data;
                    REG_RATE:    rate_q = i_cfg_data[RateW-1:0];
                    default: ;
                endcase
            end
            // outgoing point against the oldest prediction
            if (i_pt_valid && i_pt_ready) begin
                if (point_q.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected point, expected none, actual data %h arrived %b",
                             $time, i_pt_data, i_pt_arrived);
                end else begin
                    want = point_q.pop_front();
                    check_field("pos_x", want.x, i_pt_data[0 +: CW]);
                    check_field("pos_y", want.y, i_pt_data[CW +: CW]);
                    check_field("pos_z", want.z, i_pt_data[2*CW +: CW]);
                    check_field("pad", 0, i_pt_data[PtW-1:3*CW]);
                    check_field("arrived", want.arrived, i_pt_arrived);
                end
                seen++;
            end
            if (i_req_valid && i_req_ready)
                take_request(i_req_restart, i_req_step);
        end
        o_fail_count       <= fails;
        o_pending          <= point_q.size();
    end

endmodule

// ===== test/quadratic_bezier_path_stepper_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the quadratic Bezier path stepper: clock, reset, register
// setup, directed and random flights, and the verdict.
// Depends on qbps_pkg, quadratic_bezier_path_stepper and qbps_point_checker.

module quadratic_bezier_path_stepper_test
    import qbps_pkg::*;
;

    localparam int CW          = CoordWidthDef;
    localparam int PtW         = ((3*CW+7)/8)*8;
    localparam int Items       = 1000;
    localparam int PhaseItems  = 170;
    localparam int DrainCycles = 24;
    localparam int Limit       = 1000000;

    localparam logic [CW-1:0] CMax = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMin = {1'b1, {(CW-1){1'b0}}};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [StepW-1:0]  s_tdata = '0;
    logic              s_tuser = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [PtW-1:0]    m_tdata;
    logic              m_tuser;
    logic              cfg_we = 1'b0;
    logic [RegIdxW-1:0] cfg_addr = '0;
    logic [3*CW-1:0]   cfg_data = '0;

    int fail_count;
    int pending;
    int sent = 0;
    int cycles = 0;
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    quadratic_bezier_path_stepper dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_data      (cfg_data)
    );

    qbps_point_checker u_point_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_req_valid        (s_tvalid),
        .i_req_ready        (s_tready),
        .i_req_step         (s_tdata),
        .i_req_restart      (s_tuser),
        .i_pt_valid         (m_tvalid),
        .i_pt_ready         (m_tready),
        .i_pt_data          (m_tdata),
        .i_pt_arrived       (m_tuser),
        .i_cfg_we           (cfg_we),
        .i_cfg_addr         (cfg_addr),
        .i_cfg_data         (cfg_data),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial begin
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > Limit) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // point consumer: random stalls unless a steady stretch is on
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge clk);
            if (rx_steady) begin
                m_tready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else if ($urandom_range(0, 1) == 0) begin
                m_tready <= 1'b1;
                hold = $urandom_range(0, 15);
            end else begin
                m_tready <= 1'b0;
                hold = gap_len();
            end
        end
    end

    task automatic pause(input int n);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic send_request(input bit restart, input logic [StepW-1:0] step);
        s_tvalid <= 1'b1;
        s_tuser  <= restart;
        s_tdata  <= step;
        do @(posedge clk); while (!s_tready);
        sent++;
        if (!tx_steady)
            pause(gap_len());
    endtask

    // stop sending until every predicted point has left, then let the block settle
    task automatic settle(input int extra);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic load_path(input logic [3*CW-1:0] p0, input logic [3*CW-1:0] p1,
                             input logic [3*CW-1:0] p2, input logic [RateW-1:0] rate);
        cfg_we   <= 1'b1;
        cfg_addr <= REG_START;
        cfg_data <= p0;
        @(posedge clk);
        cfg_addr <= REG_CONTROL;
        cfg_data <= p1;
        @(posedge clk);
        cfg_addr <= REG_END;
        cfg_data <= p2;
        @(posedge clk);
        cfg_addr <= REG_RATE;
        cfg_data <= {{(3*CW-RateW){1'b0}}, rate};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [CW-1:0] rand_coord();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return CMax;
        else if (r == 1)
            return CMin;
        else
            return CW'($urandom);
    endfunction

    function automatic logic [3*CW-1:0] rand_point();
        return {rand_coord(), rand_coord(), rand_coord()};
    endfunction

    function automatic logic [StepW-1:0] rand_step();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r < 6)
            return StepW'($urandom_range(0, 255));
        else
            return StepW'($urandom);
    endfunction

    initial begin
        int phase;
        int phase_items;
        int ticks;
        logic [RateW-1:0] rate;
        phase    = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: tick while idle, short flight to arrival, tick after it
        send_request(1'b0, 16'hFFFF);
        send_request(1'b1, 16'h0000);
        send_request(1'b0, 16'h1234);
        send_request(1'b0, 16'hFFFF);
        send_request(1'b0, 16'h8000);
        settle(DrainCycles);

        // extreme coordinates, full rate; zero steps repeat the start point,
        // restart while armed ignores its step
        load_path({{CW{1'b0}}, CMin, CMax}, {{CW{1'b1}}, CMax, CMin},
                  {CMin, CMax, CMax}, 16'hFFFF);
        send_request(1'b1, 16'hFFFF);
        send_request(1'b0, 16'h0000);
        send_request(1'b0, 16'h0000);
        send_request(1'b0, 16'h0001);
        send_request(1'b1, 16'hFFFF);
        send_request(1'b0, 16'h0100);
        send_request(1'b0, 16'h0001);
        send_request(1'b0, 16'hFFFF);
        settle(DrainCycles);

        // zero rate: t never moves
        load_path({CMax, CMax, CMax}, {CMin, CMin, CMin}, {CMax, CMin, CMax}, 16'h0000);
        send_request(1'b1, 16'h0000);
        send_request(1'b0, 16'hFFFF);
        send_request(1'b0, 16'h8000);
        settle(DrainCycles);

        // half rate: three full steps reach the end
        load_path(rand_point(), rand_point(), rand_point(), 16'h0080);
        send_request(1'b1, 16'h5A5A);
        send_request(1'b0, 16'hFFFF);
        send_request(1'b0, 16'hFFFF);
        send_request(1'b0, 16'hFFFF);
        settle(DrainCycles);

        // random flights over changing settings
        while (sent < Items) begin
            case (phase % 6)
                0: rate = RateW'($urandom_range(1, 32));
                1: rate = '1;
                2: rate = '0;
                3: rate = RateW'($urandom);
                4: rate = RateReset;
                default: rate = RateW'($urandom_range(1, 4));
            endcase
            load_path(rand_point(), rand_point(), rand_point(), rate);
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            phase_items = 0;
            while (phase_items < PhaseItems) begin
                if ($urandom_range(0, 24) == 0)
                    settle(0);
                // a few flights start without a restart
                if ($urandom_range(0, 19) != 0) begin
                    send_request(1'b1, StepW'($urandom));
                    phase_items++;
                end
                ticks = $urandom_range(1, 48);
                repeat (ticks) begin
                    if ($urandom_range(0, 29) == 0)
                        send_request(1'b1, StepW'($urandom));
                    else
                        send_request(1'b0, rand_step());
                end
                phase_items += ticks;
            end
            settle(DrainCycles);
            phase++;
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;

        settle(DrainCycles);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/qbps_pkg.sv
design/qbps_dpath.sv
design/qbps_ctrl.sv
design/quadratic_bezier_path_stepper.sv
design/qbps_chk.sv
test/qbps_point_checker.sv
test/quadratic_bezier_path_stepper_test.sv
